### rtl/pow2_aligned_first_fit_allocator_top_defines.svh
// Assertion macros for the power-of-two aligned first-fit allocator.
`ifndef POW2_ALIGNED_FIRST_FIT_ALLOCATOR_TOP_DEFINES_SVH
`define POW2_ALIGNED_FIRST_FIT_ALLOCATOR_TOP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define PAFA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define PAFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pafa_pkg.sv
// Shared constants, codes and controller/datapath interface types of the allocator.
`timescale 1ns / 1ps

package pafa_pkg;

  localparam int unsigned MEM_UNITS_DEF = 1024;
  localparam int unsigned ROW_W         = 32;
  localparam int unsigned ROW_LOG       = 5;
  localparam int unsigned REQ_W         = 12;
  localparam int unsigned OWNER_W       = 16;
  localparam int unsigned ADDR_W        = 10;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned EXP_W         = 4;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_TOO_BIG  = 2'd2
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_MSET,
    S_MARK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic    load;
    logic    clr_wr;
    logic    scan_init;
    logic    scan_adv;
    logic    mark_init;
    logic    mark_src_hit;
    logic    mark_wr;
    logic    res_ld;
    status_t res_status;
    logic    res_use_addr;
  } pafa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic too_big;
    logic is_free;
    logic in_range;
    logic owner_nz;
    logic scan_hit;
    logic scan_end;
    logic mark_last;
  } pafa_stat_t;

endpackage

### rtl/pafa_dp.sv
// Datapath: occupancy map memory, aligned block scan, range marking and result register.
`timescale 1ns / 1ps

module pafa_dp
  import pafa_pkg::*;
#(
  parameter int unsigned MEM_UNITS = MEM_UNITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pafa_cmd_t          cmd,
  output pafa_stat_t         stat,
  input  logic               in_cmd,
  input  logic [REQ_W-1:0]   in_req_size,
  input  logic [OWNER_W-1:0] in_owner_id,
  input  logic [ADDR_W-1:0]  in_free_addr,
  output status_t            out_status,
  output logic [ADDR_W-1:0]  out_block_addr
);

  localparam int unsigned NUM_ROWS  = (MEM_UNITS + ROW_W - 1) / ROW_W;
  localparam int unsigned ROW_AW    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int unsigned NXT_W     = ROW_AW + 2;
  localparam int unsigned AW        = $clog2(MEM_UNITS);
  localparam int unsigned SW        = ((AW > REQ_W) ? AW : REQ_W) + 2;
  localparam int unsigned LAST_BITS = MEM_UNITS - (NUM_ROWS - 1) * ROW_W;

  logic [ROW_W-1:0] mem [NUM_ROWS];

  cmd_t              cmd_r;
  logic [EXP_W-1:0]  e_r, e_nxt;
  logic              too_big_r, too_big_nxt;
  logic              owner_nz_r;
  logic [ADDR_W-1:0] faddr_r;
  logic [REQ_W-1:0]  req_m1;

  logic [ROW_AW-1:0] clr_row_r, clr_row_nxt;
  logic [ROW_AW-1:0] scan_row_r, scan_row_nxt;
  logic [ROW_AW-1:0] rd_row;
  logic [ROW_W-1:0]  rd_data_r;

  logic [SW-1:0]     hit_start_r, hit_start;
  logic [SW-1:0]     lo_r, lo_nxt, last_r, last_nxt;
  logic [ROW_AW-1:0] mrow_r, mrow_nxt;
  logic              mark_val_r;

  status_t           out_status_r;
  logic [ADDR_W-1:0] out_addr_r;

  logic [SW-1:0]     size_u;
  logic              big;
  logic [NXT_W-1:0]  rpb_m1;
  logic [ROW_W-1:0]  freev [ROW_LOG+1];
  logic [ROW_W-1:0]  vmask;
  logic [ROW_W-1:0]  cand_sel;
  logic [ROW_LOG-1:0] idx;
  logic [ROW_LOG-1:0] off;
  logic              sm_hit;
  logic [NXT_W-1:0]  row_ext;
  logic              row_clear;
  logic              eob;
  logic              hit;
  logic [NXT_W-1:0]  blk_row;
  logic [NXT_W-1:0]  next_row;

  logic [SW-1:0]     base;
  logic [SW-1:0]     end_excl;
  logic [SW-1:0]     base_sh, lo_sh, last_sh;
  logic [ROW_AW-1:0] lo_row, last_row;
  logic [ROW_LOG-1:0] sbit, ebit;
  logic [ROW_W-1:0]  mark_mask;

  logic              wr_en;
  logic [ROW_AW-1:0] wr_row;
  logic [ROW_W-1:0]  wr_mask;
  logic [ROW_W-1:0]  wr_data;

  // request decode
  always_comb begin
    req_m1 = in_req_size - REQ_W'(1);
    e_nxt  = '0;
    if (in_req_size > REQ_W'(1)) begin
      for (int i = 0; i < REQ_W; i++) begin
        if (req_m1[i]) e_nxt = EXP_W'(i + 1);
      end
    end
    too_big_nxt = SW'(in_req_size) > SW'(MEM_UNITS);
  end

  assign size_u = SW'(1) << e_r;
  assign big    = e_r > EXP_W'(ROW_LOG);
  assign rpb_m1 = big ? ((NXT_W'(1) << (e_r - EXP_W'(ROW_LOG))) - NXT_W'(1)) : '0;

  // aligned free blocks within the current row
  always_comb begin
    freev[0] = ~rd_data_r;
    for (int l = 1; l <= ROW_LOG; l++) begin
      freev[l] = '0;
      for (int k = 0; k < (ROW_W >> l); k++) begin
        freev[l][k] = freev[l-1][2*k] & freev[l-1][2*k+1];
      end
    end
    for (int b = 0; b < ROW_W; b++) begin
      vmask[b] = (scan_row_r != ROW_AW'(NUM_ROWS - 1)) || (b < LAST_BITS);
    end
    cand_sel = '0;
    for (int l = 0; l <= ROW_LOG; l++) begin
      if (e_r == EXP_W'(l)) begin
        for (int k = 0; k < (ROW_W >> l); k++) begin
          cand_sel[k] = freev[l][k] & vmask[k << l];
        end
      end
    end
    sm_hit = |cand_sel;
    idx    = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (cand_sel[i]) idx = ROW_LOG'(i);
    end
    off = idx << e_r;
  end

  // scan step: hit detection and next row to read
  always_comb begin
    row_ext   = NXT_W'(scan_row_r);
    row_clear = ~|rd_data_r;
    eob       = ((row_ext & rpb_m1) == rpb_m1) || (scan_row_r == ROW_AW'(NUM_ROWS - 1));
    blk_row   = row_ext & ~rpb_m1;
    hit       = big ? (row_clear && eob) : sm_hit;
    if (big && !row_clear) begin
      next_row = (row_ext | rpb_m1) + NXT_W'(1);
    end else begin
      next_row = row_ext + NXT_W'(1);
    end
    if (big) begin
      hit_start = SW'(blk_row) << ROW_LOG;
    end else begin
      hit_start = (SW'(scan_row_r) << ROW_LOG) | SW'(off);
    end
  end

  assign rd_row = cmd.scan_init ? '0 : next_row[ROW_AW-1:0];

  always_comb begin
    scan_row_nxt = scan_row_r;
    if (cmd.scan_init) begin
      scan_row_nxt = '0;
    end else if (cmd.scan_adv) begin
      scan_row_nxt = next_row[ROW_AW-1:0];
    end
  end

  // range to mark, clipped at the end of memory
  always_comb begin
    base     = cmd.mark_src_hit ? hit_start_r : SW'(faddr_r);
    end_excl = base + size_u;
    lo_nxt   = base;
    last_nxt = ((end_excl > SW'(MEM_UNITS)) ? SW'(MEM_UNITS) : end_excl) - SW'(1);
    base_sh  = base >> ROW_LOG;
    mrow_nxt = mrow_r;
    if (cmd.mark_init) begin
      mrow_nxt = base_sh[ROW_AW-1:0];
    end else if (cmd.mark_wr) begin
      mrow_nxt = mrow_r + ROW_AW'(1);
    end
  end

  always_comb begin
    lo_sh     = lo_r >> ROW_LOG;
    last_sh   = last_r >> ROW_LOG;
    lo_row    = lo_sh[ROW_AW-1:0];
    last_row  = last_sh[ROW_AW-1:0];
    sbit      = (mrow_r == lo_row) ? lo_r[ROW_LOG-1:0] : '0;
    ebit      = (mrow_r == last_row) ? last_r[ROW_LOG-1:0] : '1;
    mark_mask = ({ROW_W{1'b1}} << sbit) & ({ROW_W{1'b1}} >> (ROW_LOG'(ROW_W - 1) - ebit));
  end

  assign clr_row_nxt = cmd.clr_wr ? clr_row_r + ROW_AW'(1) : clr_row_r;

  assign wr_en   = cmd.clr_wr | cmd.mark_wr;
  assign wr_row  = cmd.clr_wr ? clr_row_r : mrow_r;
  assign wr_mask = cmd.clr_wr ? {ROW_W{1'b1}} : mark_mask;
  assign wr_data = cmd.clr_wr ? '0 : {ROW_W{mark_val_r}};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int b = 0; b < ROW_W; b++) begin
        if (wr_mask[b]) mem[wr_row][b] <= wr_data[b];
      end
    end
    rd_data_r <= mem[rd_row];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_row_r <= '0;
    end else begin
      clr_row_r <= clr_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r      <= cmd_t'(in_cmd);
      e_r        <= e_nxt;
      too_big_r  <= too_big_nxt;
      owner_nz_r <= |in_owner_id;
      faddr_r    <= in_free_addr;
    end
    scan_row_r <= scan_row_nxt;
    if (cmd.scan_adv) begin
      hit_start_r <= hit_start;
    end
    if (cmd.mark_init) begin
      lo_r       <= lo_nxt;
      last_r     <= last_nxt;
      mark_val_r <= cmd.mark_src_hit;
    end
    mrow_r <= mrow_nxt;
    if (cmd.res_ld) begin
      out_status_r <= cmd.res_status;
      out_addr_r   <= cmd.res_use_addr ? hit_start_r[ADDR_W-1:0] : '0;
    end
  end

  always_comb begin
    stat.clr_last  = clr_row_r == ROW_AW'(NUM_ROWS - 1);
    stat.too_big   = too_big_r;
    stat.is_free   = cmd_r == CMD_FREE;
    stat.in_range  = SW'(faddr_r) < SW'(MEM_UNITS);
    stat.owner_nz  = owner_nz_r;
    stat.scan_hit  = hit;
    stat.scan_end  = !hit && (next_row >= NXT_W'(NUM_ROWS));
    stat.mark_last = mrow_r == last_row;
  end

  assign out_status     = out_status_r;
  assign out_block_addr = out_addr_r;

endmodule

### rtl/pafa_ctrl.sv
// Controller state machine: clearing pass, request sequencing and result handshake.
`timescale 1ns / 1ps

module pafa_ctrl
  import pafa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output pafa_cmd_t  cmd,
  input  pafa_stat_t stat
);

  state_t  state_r, state_nxt;
  logic    out_valid_r, out_valid_nxt;
  status_t pend_status_r, pend_status_nxt;
  logic    pend_addr_r, pend_addr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    pend_addr_r   <= pend_addr_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    pend_status_nxt  = pend_status_r;
    pend_addr_nxt    = pend_addr_r;
    in_ready         = 1'b0;
    cmd              = '0;
    cmd.res_status   = pend_status_r;
    cmd.res_use_addr = pend_addr_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (stat.too_big) begin
          pend_status_nxt = ST_TOO_BIG;
          pend_addr_nxt   = 1'b0;
          state_nxt       = S_RESP;
        end else if (stat.is_free) begin
          pend_status_nxt = ST_DONE;
          pend_addr_nxt   = 1'b0;
          if (stat.in_range) begin
            cmd.mark_init = 1'b1;
            state_nxt     = S_MARK;
          end else begin
            state_nxt = S_RESP;
          end
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_adv = 1'b1;
        priority if (stat.scan_hit) begin
          pend_status_nxt = ST_DONE;
          pend_addr_nxt   = 1'b1;
          state_nxt       = stat.owner_nz ? S_MSET : S_RESP;
        end else if (stat.scan_end) begin
          pend_status_nxt = ST_NO_SPACE;
          pend_addr_nxt   = 1'b0;
          state_nxt       = S_RESP;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_MSET: begin
        cmd.mark_init    = 1'b1;
        cmd.mark_src_hit = 1'b1;
        state_nxt        = S_MARK;
      end
      S_MARK: begin
        cmd.mark_wr = 1'b1;
        if (stat.mark_last) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r & ~out_ready) | cmd.res_ld;
  assign out_valid     = out_valid_r;

endmodule

### rtl/pow2_aligned_first_fit_allocator_top.sv
// Sequence: a too-big request goes from DECODE to RESP; an in-range free marks its rows in MARK;
// an allocate scans rows in SCAN, then claims the block in MSET and MARK when owner is nonzero.
// One 32-unit map row per cycle. One transaction at a time: in_ready is high only in IDLE.
// The next transaction is taken while a finished result waits on the output.
// Reset: synchronous active-low rst_n starts a clearing pass over every map row that
// frees every unit; in_ready stays low until it ends.
`timescale 1ns / 1ps
`include "pow2_aligned_first_fit_allocator_top_defines.svh"

module pow2_aligned_first_fit_allocator_top
  import pafa_pkg::*;
#(
  parameter int unsigned MEM_UNITS = MEM_UNITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [REQ_W-1:0]    in_req_size,
  input  logic [OWNER_W-1:0]  in_owner_id,
  input  logic [ADDR_W-1:0]   in_free_addr,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [ADDR_W-1:0]   out_block_addr
);

  pafa_cmd_t  dp_cmd;
  pafa_stat_t dp_stat;
  status_t    dp_status;

  pafa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  pafa_dp #(
    .MEM_UNITS (MEM_UNITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (dp_cmd),
    .stat           (dp_stat),
    .in_cmd         (in_cmd),
    .in_req_size    (in_req_size),
    .in_owner_id    (in_owner_id),
    .in_free_addr   (in_free_addr),
    .out_status     (dp_status),
    .out_block_addr (out_block_addr)
  );

  assign out_status = dp_status;

  `PAFA_ASSERT_NEXT(a_accept_drops_ready, in_valid && in_ready, !in_ready, "ready after accept")
  `PAFA_ASSERT_SAME(a_fail_addr_zero, out_valid && (dp_status != ST_DONE), out_block_addr == '0, "nonzero address on failure")
  `PAFA_ASSERT_SAME(a_clear_blocks_input, dp_cmd.clr_wr, !in_ready && !dp_cmd.mark_wr, "input open during clear")

endmodule
